// ===== rtl/rtpvp_pkg.sv =====
// Package for the RTP video packetizer: header byte constants and widths.
// No dependencies.
package rtpvp_pkg;
	localparam logic [7:0] RTP_VPX      = 8'h90;
	localparam logic [7:0] RTP_PT       = 8'd96;
	localparam logic [7:0] EXT_ID0      = 8'hBE;
	localparam logic [7:0] EXT_ID1      = 8'hDE;
	localparam logic [7:0] VH_TAG       = 8'h10;
	localparam logic [7:0] FLAG_FIRST   = 8'h04;
	localparam logic [7:0] FLAG_LAST    = 8'h02;
	localparam logic [7:0] FLAG_MID     = 8'h01;
	localparam logic [7:0] FH_KEY       = 8'h02;
	localparam logic [7:0] FH_DELTA     = 8'h01;
	localparam logic [11:0] VH_BYTES    = 12'd16;
	localparam logic [11:0] MIN_PAYLOAD = 12'd25;
	localparam logic [11:0] SMALL_CAP   = 12'd9;
	localparam logic [22:0] FH_BYTES    = 23'd8;
	localparam logic [5:0] IDX_HDR_END  = 6'd31;
	localparam logic [5:0] IDX_DATA     = 6'd40;
	localparam int DIV_STEPS            = 23;
endpackage

// ===== rtl/rtp_video_frame_packetizer_top.sv =====
// RTP video frame packetizer top level: sequencer, packet-count divider, byte output.
// Depends on rtpvp_pkg.
// Each data byte passes S_IDLE, S_PROC and S_EMIT and is registered on the output; an accepted
// frame start first computes the packet count (one restoring division step per cycle in S_DIV).
// A new datagram emits its header bytes (32 or 40) first; no new input is taken until the byte is out.
// Reset: arst_n clears the counters, state and output valid; payload_q returns to 1024.
module rtp_video_frame_packetizer_top #(
	parameter int MAX_PACKETS     = 1023,
	parameter int MAX_FRAME_BYTES = 4194303
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        frame_start,
	input  logic [21:0] frame_length,
	input  logic        key_flag,
	input  logic [31:0] timestamp,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        datagram_end,
	output logic        run_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data
);
	typedef enum logic [1:0] {S_IDLE, S_DIV, S_PROC, S_EMIT} state_t;

	state_t      state_q;
	logic [11:0] payload_q;
	logic [15:0] seq_q;
	logic [23:0] spc_q;
	logic [31:0] fc_q;
	logic [9:0]  pif_q, pos_q;
	logic [11:0] cf_q, cf_new_q;
	logic [22:0] bl_q, bl_new_q;
	logic        key_q, drop_q;
	logic [31:0] ts_q;
	logic [21:0] len_q;
	logic        key_in_q;
	logic [31:0] ts_in_q;
	logic [7:0]  data_q;
	logic [22:0] num_q, quot_q;
	logic [12:0] rem_q;
	logic [4:0]  cnt_q;
	logic [5:0]  idx_q;
	logic        hdr_q, fh_q, end_q;
	logic        out_valid_q, out_end_q, out_last_q;
	logic [7:0]  out_byte_q;

	logic [11:0] cap, divisor;
	logic [12:0] rem_sh;
	logic        rem_ge;
	logic        hdr, fh;
	logic [11:0] cf_new;
	logic [22:0] bl_new;
	logic [7:0]  flags, next_byte;
	logic        load;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign datagram_end = out_end_q;
	assign run_last = out_last_q;

	assign cap = (payload_q >= rtpvp_pkg::MIN_PAYLOAD) ? payload_q - rtpvp_pkg::VH_BYTES
		: rtpvp_pkg::SMALL_CAP;
	assign divisor = payload_q - rtpvp_pkg::VH_BYTES;
	assign rem_sh = {rem_q[11:0], num_q[22]};
	assign rem_ge = rem_sh >= {1'b0, divisor};

	assign hdr = (cf_q == 12'd0);
	assign fh = hdr && (pos_q == 10'd0) && (bl_q > rtpvp_pkg::FH_BYTES);
	assign cf_new = (fh ? 12'd8 : cf_q) + 12'd1;
	assign bl_new = bl_q - (fh ? rtpvp_pkg::FH_BYTES : 23'd0) - 23'd1;

	assign flags = ((pos_q == 10'd0) ? rtpvp_pkg::FLAG_FIRST : rtpvp_pkg::FLAG_MID)
		| (((pos_q + 10'd1) == pif_q) ? rtpvp_pkg::FLAG_LAST : 8'h00);
	assign load = !out_valid_q || out_ready;

	always_comb begin
		case (idx_q)
			6'd0: next_byte = rtpvp_pkg::RTP_VPX;
			6'd1: next_byte = rtpvp_pkg::RTP_PT;
			6'd2: next_byte = seq_q[15:8];
			6'd3: next_byte = seq_q[7:0];
			6'd4: next_byte = ts_q[31:24];
			6'd5: next_byte = ts_q[23:16];
			6'd6: next_byte = ts_q[15:8];
			6'd7: next_byte = ts_q[7:0];
			6'd12: next_byte = rtpvp_pkg::EXT_ID0;
			6'd13: next_byte = rtpvp_pkg::EXT_ID1;
			6'd17: next_byte = spc_q[7:0];
			6'd18: next_byte = spc_q[15:8];
			6'd19: next_byte = spc_q[23:16];
			6'd20: next_byte = fc_q[7:0];
			6'd21: next_byte = fc_q[15:8];
			6'd22: next_byte = fc_q[23:16];
			6'd23: next_byte = fc_q[31:24];
			6'd24: next_byte = flags;
			6'd26: next_byte = rtpvp_pkg::VH_TAG;
			6'd29: next_byte = {pos_q[3:0], 4'h0};
			6'd30: next_byte = {pif_q[1:0], pos_q[9:4]};
			6'd31: next_byte = pif_q[9:2];
			6'd32: next_byte = 8'h01;
			6'd35: next_byte = key_q ? rtpvp_pkg::FH_KEY : rtpvp_pkg::FH_DELTA;
			6'd40: next_byte = data_q;
			default: next_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			payload_q <= 12'd1024;
			seq_q <= '0;
			spc_q <= '0;
			fc_q <= '0;
			pif_q <= '0;
			pos_q <= '0;
			cf_q <= '0;
			bl_q <= '0;
			key_q <= 1'b0;
			ts_q <= '0;
			drop_q <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cfg_valid) begin
				payload_q <= cfg_data;
			end
			if (out_valid_q && out_ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						len_q <= frame_length;
						key_in_q <= key_flag;
						ts_in_q <= timestamp;
						data_q <= data_byte;
						if (frame_start) begin
							pos_q <= '0;
							cf_q <= '0;
							pif_q <= '0;
							if (frame_length == 22'd0) begin
								bl_q <= '0;
								drop_q <= 1'b0;
								state_q <= S_IDLE;
							end else if (payload_q < rtpvp_pkg::MIN_PAYLOAD
								|| {1'b0, frame_length} > 23'(MAX_FRAME_BYTES)) begin
								drop_q <= 1'b1;
								bl_q <= {1'b0, frame_length};
								state_q <= S_PROC;
							end else begin
								bl_q <= '0;
								drop_q <= 1'b0;
								num_q <= {1'b0, frame_length} + rtpvp_pkg::FH_BYTES
									+ {11'd0, payload_q} - 23'd17;
								rem_q <= '0;
								cnt_q <= '0;
								state_q <= S_DIV;
							end
						end else begin
							state_q <= S_PROC;
						end
					end
				end
				S_DIV: begin
					num_q <= {num_q[21:0], 1'b0};
					rem_q <= rem_ge ? rem_sh - {1'b0, divisor} : rem_sh;
					quot_q <= {quot_q[21:0], rem_ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(rtpvp_pkg::DIV_STEPS)) begin
						state_q <= S_PROC;
						if (quot_q > 23'(MAX_PACKETS)) begin
							drop_q <= 1'b1;
							bl_q <= {1'b0, len_q};
						end else begin
							pif_q <= quot_q[9:0];
							bl_q <= {1'b0, len_q} + rtpvp_pkg::FH_BYTES;
							key_q <= key_in_q;
							ts_q <= ts_in_q;
						end
					end
				end
				S_PROC: begin
					if (bl_q == 23'd0) begin
						state_q <= S_IDLE;
					end else if (drop_q) begin
						bl_q <= bl_q - 23'd1;
						if (bl_q == 23'd1) begin
							drop_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end else begin
						hdr_q <= hdr;
						fh_q <= fh;
						cf_new_q <= cf_new;
						bl_new_q <= bl_new;
						end_q <= (cf_new >= cap) || (bl_new == 23'd0);
						idx_q <= hdr ? 6'd0 : rtpvp_pkg::IDX_DATA;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						out_byte_q <= next_byte;
						out_end_q <= (idx_q == rtpvp_pkg::IDX_DATA) && end_q;
						out_last_q <= (idx_q == rtpvp_pkg::IDX_DATA);
						if (idx_q == rtpvp_pkg::IDX_DATA) begin
							cf_q <= end_q ? 12'd0 : cf_new_q;
							bl_q <= bl_new_q;
							if (end_q) begin
								pos_q <= pos_q + 10'd1;
								if (bl_new_q == 23'd0) begin
									fc_q <= fc_q + 32'd1;
								end
							end
							if (hdr_q) begin
								seq_q <= seq_q + 16'd1;
								spc_q <= spc_q + 24'd1;
							end
							state_q <= S_IDLE;
						end else if (idx_q == rtpvp_pkg::IDX_HDR_END && !fh_q) begin
							idx_q <= rtpvp_pkg::IDX_DATA;
						end else begin
							idx_q <= idx_q + 6'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_drop_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (bl_q != 23'd0))
		else $error("dropping with no bytes left");
	a_drop_no_packets: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (pif_q == 10'd0))
		else $error("dropped frame holds a packet count");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_byte)))
		else $error("output byte changed while stalled");
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV || state_q == S_EMIT) |-> !in_ready)
		else $error("input taken while busy");
endmodule

// ===== sim/tb.sv =====
// Testbench for rtp_video_frame_packetizer_top: directed table, then random frames.
// Output bytes are checked against an in-bench packetizer model. Depends on rtpvp_pkg.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE = 64;

	typedef struct packed {
		logic        start;
		logic [21:0] len;
		logic        key;
		logic [31:0] ts;
		logic [7:0]  data;
		logic        none;
	} stim_t;

	typedef struct {
		logic [7:0] b;
		logic       e;
		logic       l;
	} dgram_byte_t;

	logic        clk, arst_n;
	logic        in_valid, in_ready, frame_start, key_flag;
	logic [21:0] frame_length;
	logic [31:0] timestamp;
	logic [7:0]  data_byte;
	logic        out_valid, out_ready, datagram_end, run_last;
	logic [7:0]  out_byte;
	logic        cfg_valid, cfg_ready;
	logic [11:0] cfg_data;

	rtp_video_frame_packetizer_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.frame_start(frame_start), .frame_length(frame_length), .key_flag(key_flag),
		.timestamp(timestamp), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_byte(out_byte), .datagram_end(datagram_end), .run_last(run_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	dgram_byte_t dgram_q[$];
	int errors = 0;
	int cycles = 0;
	int idle_in = 37;
	int idle_out = 55;

	// packetizer model state
	logic [11:0] m_psize;
	logic [15:0] m_seq;
	logic [23:0] m_spc;
	logic [31:0] m_fc;
	logic [9:0]  m_npk, m_pos;
	logic [11:0] m_fill;
	logic [22:0] m_left;
	logic        m_key, m_drop;
	logic [31:0] m_ts;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	function automatic void push_byte(input logic [7:0] b, input logic e);
		dgram_byte_t d;
		d.b = b;
		d.e = e;
		d.l = 1'b0;
		dgram_q.insert(dgram_q.size(), d);
	endfunction

	function automatic void push_le32(input logic [31:0] v);
		push_byte(v[7:0], 1'b0); push_byte(v[15:8], 1'b0);
		push_byte(v[23:16], 1'b0); push_byte(v[31:24], 1'b0);
	endfunction

	function automatic void push_be32(input logic [31:0] v);
		push_byte(v[31:24], 1'b0); push_byte(v[23:16], 1'b0);
		push_byte(v[15:8], 1'b0); push_byte(v[7:0], 1'b0);
	endfunction

	function automatic int packetize(input stim_t s);
		int n0;
		int unsigned c, framed, cnt, cap;
		logic [7:0] fl;
		logic dend;
		n0 = dgram_q.size();
		if (s.start) begin
			m_pos = '0; m_fill = '0; m_left = '0; m_drop = 1'b0; m_npk = '0;
			if (s.len == 0)
				return 0;
			if (m_psize <= 24) begin
				m_drop = 1'b1; m_left = {1'b0, s.len};
			end else begin
				c = m_psize - 16;
				framed = s.len + 8;
				cnt = (framed + c - 1) / c;
				if (cnt > 1023) begin
					m_drop = 1'b1; m_left = {1'b0, s.len};
				end else begin
					m_npk = cnt[9:0];
					m_left = framed[22:0];
					m_key = s.key;
					m_ts = s.ts;
				end
			end
		end
		if (m_left == 0)
			return 0;
		if (m_drop) begin
			m_left--;
			if (m_left == 0)
				m_drop = 1'b0;
			return 0;
		end
		cap = (m_psize >= 25) ? m_psize - 16 : 9;
		if (m_fill == 0) begin
			fl = ((m_pos == 0) ? rtpvp_pkg::FLAG_FIRST : rtpvp_pkg::FLAG_MID) |
				((m_pos + 10'd1 == m_npk) ? rtpvp_pkg::FLAG_LAST : 8'h00);
			push_byte(rtpvp_pkg::RTP_VPX, 1'b0); push_byte(rtpvp_pkg::RTP_PT, 1'b0);
			push_byte(m_seq[15:8], 1'b0); push_byte(m_seq[7:0], 1'b0);
			push_be32(m_ts);
			push_be32(32'h0);
			push_byte(rtpvp_pkg::EXT_ID0, 1'b0); push_byte(rtpvp_pkg::EXT_ID1, 1'b0);
			push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
			push_le32({m_spc, 8'h00});
			push_le32(m_fc);
			push_byte(fl, 1'b0); push_byte(8'h00, 1'b0);
			push_byte(rtpvp_pkg::VH_TAG, 1'b0); push_byte(8'h00, 1'b0);
			push_le32({m_npk, m_pos, 12'h000});
			m_seq++;
			m_spc++;
			if (m_pos == 0 && m_left > 23'd8) begin
				push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
				push_byte(m_key ? rtpvp_pkg::FH_KEY : rtpvp_pkg::FH_DELTA, 1'b0);
				push_le32(32'h0);
				m_fill = 12'd8;
				m_left = m_left - 23'd8;
			end
		end
		m_fill++;
		m_left--;
		dend = (m_fill >= cap) || (m_left == 0);
		push_byte(s.data, dend);
		if (dend) begin
			m_fill = '0;
			m_pos++;
			if (m_left == 0)
				m_fc++;
		end
		dgram_q[dgram_q.size() - 1].l = 1'b1;
		return dgram_q.size() - n0;
	endfunction

	task automatic send_item(input stim_t s, output int n);
		if ($urandom_range(99) < idle_in) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_in);
		end
		in_valid <= 1'b1;
		frame_start <= s.start;
		frame_length <= s.len;
		key_flag <= s.key;
		timestamp <= s.ts;
		data_byte <= s.data;
		do @(posedge clk); while (!in_ready);
		n = packetize(s);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (dgram_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_payload(input logic [11:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		m_psize = v;
	endtask

	always @(posedge clk) begin : rx_side
		dgram_byte_t d;
		if (arst_n && out_valid && out_ready) begin
			if (dgram_q.size() == 0) begin
				report_mismatch("unexpected byte", out_byte, 0);
			end else begin
				d = dgram_q.pop_front();
				if (out_byte !== d.b)
					report_mismatch("out_byte", out_byte, d.b);
				if (datagram_end !== d.e)
					report_mismatch("datagram_end", datagram_end, d.e);
				if (run_last !== d.l)
					report_mismatch("run_last", run_last, d.l);
			end
		end
		out_ready <= ($urandom_range(99) >= idle_out);
	end

	stim_t dir_tab [14] = '{
		'{1'b1, 22'd1,       1'b1, 32'hFFFFFFFF, 8'h00, 1'b0},
		'{1'b0, 22'h3FFFFF,  1'b1, 32'hFFFFFFFF, 8'hFF, 1'b1},
		'{1'b1, 22'd0,       1'b1, 32'hFFFFFFFF, 8'hFF, 1'b1},
		'{1'b1, 22'd3,       1'b0, 32'h00000000, 8'hFF, 1'b0},
		'{1'b0, 22'd0,       1'b0, 32'h00000000, 8'hAA, 1'b0},
		'{1'b0, 22'd0,       1'b0, 32'h00000000, 8'h55, 1'b0},
		'{1'b1, 22'd5,       1'b1, 32'h12345678, 8'h01, 1'b0},
		'{1'b0, 22'd0,       1'b0, 32'h00000000, 8'h02, 1'b0},
		'{1'b1, 22'd2,       1'b0, 32'h80000000, 8'h03, 1'b0},
		'{1'b0, 22'd0,       1'b0, 32'h00000000, 8'h04, 1'b0},
		'{1'b1, 22'h3FFFFF,  1'b1, 32'h00000000, 8'h05, 1'b1},
		'{1'b0, 22'd0,       1'b0, 32'h00000000, 8'h06, 1'b1},
		'{1'b1, 22'd0,       1'b0, 32'h00000000, 8'h07, 1'b1},
		'{1'b0, 22'd0,       1'b0, 32'h00000000, 8'h08, 1'b1}
	};

	logic [11:0] psize_plan [9] = '{12'd25, 12'd4095, 12'd24, 12'd40, 12'd0,
		12'd1024, 12'd33, 12'd4095, 12'd25};

	initial begin : stim
		stim_t s;
		int n, left, per_phase;
		arst_n = 1'b0;
		in_valid <= 1'b0; frame_start <= 1'b0; frame_length <= '0; key_flag <= 1'b0;
		timestamp <= '0; data_byte <= '0; out_ready <= 1'b0;
		cfg_valid <= 1'b0; cfg_data <= '0;
		m_psize = 12'd1024; m_seq = '0; m_spc = '0; m_fc = '0; m_npk = '0; m_pos = '0;
		m_fill = '0; m_left = '0; m_key = 1'b0; m_drop = 1'b0; m_ts = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			send_item(dir_tab[i], n);
			if (dir_tab[i].none && n != 0)
				report_mismatch("model output on silent row", n, 0);
		end

		left = 0;
		for (int ph = 0; ph < 9; ph++) begin
			if (ph < 3) begin
				idle_in = 37; idle_out = 55;
			end else if (ph < 6) begin
				idle_in = 55; idle_out = 37;
			end else begin
				idle_in = 0; idle_out = 0;
			end
			write_payload(psize_plan[ph]);
			for (per_phase = 0; per_phase < 33; per_phase++) begin
				s.start = 1'b0;
				s.len = 22'($urandom);
				s.key = 1'($urandom);
				s.ts = $urandom;
				s.data = 8'($urandom);
				s.none = 1'b0;
				if (left == 0 && $urandom_range(9) == 0) begin
					s.start = 1'b0;
				end else if (left == 0 || $urandom_range(99) < 3) begin
					s.start = 1'b1;
					case ($urandom_range(19))
						0: s.len = '0;
						1: s.len = 22'(22'h3FFFFF - $urandom_range(3));
						2: s.len = 22'($urandom_range(300, 100));
						3: s.len = 22'h200000 | 22'($urandom);
						default: s.len = 22'($urandom_range(60, 1));
					endcase
					left = (s.len > 400) ? $urandom_range(4, 1) : int'(s.len);
				end
				if (left > 0)
					left--;
				send_item(s, n);
				if (ph == 3 && per_phase == 5) begin
					in_valid <= 1'b0;
					while (dgram_q.size() != 0)
						@(posedge clk);
				end
			end
		end

		drain();
		if (errors == 0 && dgram_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/rtpvp_pkg.sv
rtl/rtp_video_frame_packetizer_top.sv
sim/tb.sv
